### hdl/sha1_message_digest_core_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 digest core assertion macros
// Concurrent check wrappers used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH

// same-cycle implication
`define SHA1MD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sha1md same-cycle check failed");

// next-cycle implication
`define SHA1MD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sha1md next-cycle check failed");

`endif

### hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Types, constants and round functions shared by the digest core modules.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned NUM_CV    = 5;
  localparam int unsigned NUM_ROUND = 80;

  typedef logic [NUM_CV-1:0][31:0] cv_t;
  typedef logic [15:0][31:0]       win_t;

  localparam cv_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                        32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd4;
  localparam logic [6:0] RND_LAST  = 7'(NUM_ROUND - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic       start;
    logic       init;
    logic       wr_en;
    logic [3:0] idx;
    logic [1:0] lane;
    logic [7:0] data;
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

### hdl/sha1md_if.sv
// ----------------------------------------------------------------------------
// SHA-1 digest core channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       final_req;

  modport source (output valid, message_byte, byte_present, final_req, input ready);
  modport sink   (input valid, message_byte, byte_present, final_req, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha1md_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Block buffer and message schedule window, one compression round per cycle,
// chaining value update after round 79.
// ----------------------------------------------------------------------------
module sha1md_round (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1md_pkg::rnd_ctl_t ctl,
  output logic                done,
  output sha1md_pkg::cv_t     cv
);

  sha1md_pkg::win_t w_r;
  sha1md_pkg::cv_t  cv_r;
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [6:0]       rnd_r;
  logic             busy_r, add_r, done_r;
  logic [31:0]      t_nxt, w_nxt, x_nxt;

  always_comb begin
    t_nxt = {a_r[26:0], a_r[31:27]} + sha1md_pkg::round_f(rnd_r, b_r, c_r, d_r)
            + e_r + sha1md_pkg::round_k(rnd_r) + w_r[0];
    x_nxt = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_nxt = {x_nxt[30:0], x_nxt[31]};
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      w_r[ctl.idx][{~ctl.lane, 3'b000} +: 8] <= ctl.data;
    end else if (busy_r) begin
      w_r <= {w_nxt, w_r[15:1]};
    end
    if (ctl.start) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
      e_r <= cv_r[4];
    end else if (busy_r) begin
      a_r <= t_nxt;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      cv_r   <= sha1md_pkg::IV;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == sha1md_pkg::RND_LAST) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end
      if (add_r) begin
        add_r  <= 1'b0;
        done_r <= 1'b1;
        cv_r   <= {cv_r[4] + e_r, cv_r[3] + d_r, cv_r[2] + c_r,
                   cv_r[1] + b_r, cv_r[0] + a_r};
      end else if (ctl.init) begin
        cv_r <= sha1md_pkg::IV;
      end
    end
  end

  assign done = done_r;
  assign cv   = cv_r;

endmodule

### hdl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Absorbs one message byte per request, pads on the final request and
// returns the five digest words.
// ----------------------------------------------------------------------------
// A byte that does not complete a block is only written to the block buffer;
// one that completes a block also starts the 80-round unit and its chaining add.
// A final request writes the pad bytes (9 to 72) and runs one or two block
// compressions, then shows five digest words, one per cycle when taken.
// One request at a time: in_chan.ready is high only between requests.
// rst_n (synchronous) loads the initial hash and clears the counts.
module sha1_message_digest_core (
  input  logic                clk,
  input  logic                rst_n,
  sha1md_in_if.sink           in_chan,
  sha1md_out_if.source        out_chan
);

  sha1md_pkg::state_t   state_r, state_nxt;
  logic [5:0]           fill_r, fill_nxt;
  logic [63:0]          bits_r, bits_nxt;
  logic [63:0]          len_r, len_nxt;
  logic                 pad_r, pad_nxt;
  logic                 first_r, first_nxt;
  logic                 lenph_r, lenph_nxt;
  logic                 lastlen_r, lastlen_nxt;
  logic [2:0]           oidx_r, oidx_nxt;
  sha1md_pkg::rnd_ctl_t ctl;
  sha1md_pkg::cv_t      cv;
  logic                 rnd_done;
  logic                 in_acc, out_acc, full, len_byte;

  sha1md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .done  (rnd_done),
    .cv    (cv)
  );

  assign in_chan.ready        = (state_r == sha1md_pkg::S_IDLE);
  assign out_chan.valid       = (state_r == sha1md_pkg::S_OUT);
  assign out_chan.digest_word = cv[oidx_r];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == sha1md_pkg::LAST_IDX);

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_acc  = out_chan.valid && out_chan.ready;
  assign full     = (fill_r == sha1md_pkg::FILL_LAST);
  assign len_byte = !first_r && (lenph_r || fill_r == sha1md_pkg::LEN_START);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    bits_nxt    = bits_r;
    len_nxt     = len_r;
    pad_nxt     = pad_r;
    first_nxt   = first_r;
    lenph_nxt   = lenph_r;
    lastlen_nxt = lastlen_r;
    oidx_nxt    = oidx_r;
    ctl         = '0;
    ctl.idx     = fill_r[5:2];
    ctl.lane    = fill_r[1:0];
    unique case (state_r)
      sha1md_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_chan.byte_present) begin
            ctl.wr_en = 1'b1;
            ctl.data  = in_chan.message_byte;
            ctl.start = full;
            fill_nxt  = fill_r + 6'd1;
            bits_nxt  = bits_r + 64'd8;
          end
          if (in_chan.final_req) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
            lenph_nxt = 1'b0;
            len_nxt   = bits_r + (in_chan.byte_present ? 64'd8 : 64'd0);
            bits_nxt  = '0;
          end
          if (in_chan.byte_present && full) begin
            state_nxt = sha1md_pkg::S_COMP;
          end else if (in_chan.final_req) begin
            state_nxt = sha1md_pkg::S_PAD;
          end
        end
      end
      sha1md_pkg::S_PAD: begin
        ctl.wr_en = 1'b1;
        ctl.start = full;
        fill_nxt  = fill_r + 6'd1;
        first_nxt = 1'b0;
        if (first_r) begin
          ctl.data = sha1md_pkg::PAD_BYTE;
        end else if (len_byte) begin
          ctl.data  = len_r[63:56];
          len_nxt   = {len_r[55:0], 8'h00};
          lenph_nxt = 1'b1;
        end else begin
          ctl.data = 8'h00;
        end
        if (full) begin
          state_nxt   = sha1md_pkg::S_COMP;
          lastlen_nxt = len_byte;
        end
      end
      sha1md_pkg::S_COMP: begin
        if (rnd_done) begin
          if (lastlen_r) begin
            state_nxt = sha1md_pkg::S_OUT;
            oidx_nxt  = '0;
          end else if (pad_r) begin
            state_nxt = sha1md_pkg::S_PAD;
          end else begin
            state_nxt = sha1md_pkg::S_IDLE;
          end
        end
      end
      sha1md_pkg::S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == sha1md_pkg::LAST_IDX) begin
            ctl.init    = 1'b1;
            pad_nxt     = 1'b0;
            lenph_nxt   = 1'b0;
            lastlen_nxt = 1'b0;
            state_nxt   = sha1md_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha1md_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1md_pkg::S_IDLE;
      fill_r    <= '0;
      bits_r    <= '0;
      pad_r     <= 1'b0;
      first_r   <= 1'b0;
      lenph_r   <= 1'b0;
      lastlen_r <= 1'b0;
      oidx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      pad_r     <= pad_nxt;
      first_r   <= first_nxt;
      lenph_r   <= lenph_nxt;
      lastlen_r <= lastlen_nxt;
      oidx_r    <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

endmodule

### hdl/sha1md_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 digest core port checker
// Watches the request and digest channels of the core.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_core_macros.svh"

module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHA1MD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))
  `SHA1MD_ASSERT_SAME(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `SHA1MD_ASSERT_SAME(a_last_idx, clk, rst_n, out_valid, last_word == (word_index == 3'd4))
  `SHA1MD_ASSERT_NEXT(a_end_digest, clk, rst_n, out_valid && out_ready && last_word, !out_valid && in_ready)

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .digest_word (out_chan.digest_word),
  .word_index  (out_chan.word_index),
  .last_word   (out_chan.last_word)
);
